// ===== design/lce_tlf_pkg.sv =====
// Shared types, field layout and codes for the two-level fingerprint LCE core.
// Used by the core and its port checker; depends on nothing else.
package lce_tlf_pkg;

	localparam int MAX_LEN_DEF = 4096;
	localparam int CHAR_BITS   = 8;
	localparam int GROUP_BITS  = 12;
	localparam int RANK_BITS   = 12;
	localparam int REG_BITS    = 13;
	localparam int SUM_BITS    = 15;
	localparam int IDX_BITS    = 2;

	// Input tdata layout, lowest bit first.
	localparam int RANK_LSB   = 0;
	localparam int CHAR_LSB   = RANK_LSB + RANK_BITS;
	localparam int START_LSB  = CHAR_LSB + CHAR_BITS;
	localparam int LCP_LSB    = START_LSB + RANK_BITS;
	localparam int QFIRST_LSB = LCP_LSB + REG_BITS;
	localparam int QSEC_LSB   = QFIRST_LSB + REG_BITS;
	localparam int S_FIELD_BITS = QSEC_LSB + REG_BITS;
	localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((REG_BITS + 7) / 8) * 8;

	typedef logic [CHAR_BITS-1:0]  char_t;
	typedef logic [GROUP_BITS-1:0] grp_t;
	typedef logic [RANK_BITS-1:0]  rank_t;
	typedef logic [REG_BITS-1:0]   reg_t;
	typedef logic [SUM_BITS-1:0]   sum_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	// Configuration register indexes.
	localparam idx_t REG_STRING_LENGTH = 2'd0;
	localparam idx_t REG_FINE_STRIDE   = 2'd1;
	localparam idx_t REG_COARSE_STRIDE = 2'd2;

	// Item kinds carried in s_tuser.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		LVL_COARSE,
		LVL_FINE,
		LVL_CHAR
	} level_t;

endpackage

// ===== design/lce_two_level_fingerprint_core.sv =====
// Longest-common-extension core with coarse and fine fingerprint groups.
// Depends on lce_tlf_pkg and lce_tlf_ram; a port checker is bound in separately.
//
// Load items (s_tuser = 0) leave the core idle and give no result. A query
// (s_tuser = 1) with equal positions goes straight to the done state and then
// gives one result. Any other query walks the group and text RAMs in steps
// of one RAM read and one compare, first over coarse groups, then fine groups,
// then characters, until a character compare fails. The next item is
// accepted once the query has moved its result to the output register,
// even if that result has not yet been taken. Both RAMs hold MAX_LEN entries
// and are not cleared; a query must only reach positions that were loaded.
module lce_two_level_fingerprint_core #(
	parameter int MAX_LEN = lce_tlf_pkg::MAX_LEN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// rank, text_char, suffix_start, common_prefix, query_first, query_second
	input  logic [lce_tlf_pkg::S_TDATA_BITS-1:0] s_tdata,
	// op
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// extension_length
	output logic [lce_tlf_pkg::M_TDATA_BITS-1:0] m_tdata,
	input  logic                                 cfg_we,
	input  logic [lce_tlf_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [lce_tlf_pkg::REG_BITS-1:0]     cfg_wdata
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int GW = 2 * lce_tlf_pkg::GROUP_BITS;

	lce_tlf_pkg::state_t state_q, state_d;
	lce_tlf_pkg::level_t level_q;

	lce_tlf_pkg::reg_t len_q, fine_q, coarse_q;
	lce_tlf_pkg::reg_t n_eff, sf_eff, sc_eff;

	lce_tlf_pkg::grp_t fine_run_q, coarse_run_q, fine_run_d, coarse_run_d;

	lce_tlf_pkg::rank_t in_rank, in_start;
	lce_tlf_pkg::char_t in_char;
	lce_tlf_pkg::reg_t  in_lcp, in_i, in_j, in_far, in_bound, in_self;

	lce_tlf_pkg::reg_t i_q, j_q, bound_q, result;
	lce_tlf_pkg::sum_t t_q, pos_a, pos_b, step;
	logic              inr_q, match, accept, load_acc, query_acc, out_load;

	logic              text_we, grp_we;
	logic [AW-1:0]     raddr_a, raddr_b;
	lce_tlf_pkg::char_t text_a, text_b;
	logic [GW-1:0]     grp_a, grp_b;

	logic               m_valid_q;
	lce_tlf_pkg::reg_t  m_len_q;

	// Unpack the input item.
	assign in_rank  = s_tdata[lce_tlf_pkg::RANK_LSB +: lce_tlf_pkg::RANK_BITS];
	assign in_char  = s_tdata[lce_tlf_pkg::CHAR_LSB +: lce_tlf_pkg::CHAR_BITS];
	assign in_start = s_tdata[lce_tlf_pkg::START_LSB +: lce_tlf_pkg::RANK_BITS];
	assign in_lcp   = s_tdata[lce_tlf_pkg::LCP_LSB +: lce_tlf_pkg::REG_BITS];
	assign in_i     = s_tdata[lce_tlf_pkg::QFIRST_LSB +: lce_tlf_pkg::REG_BITS];
	assign in_j     = s_tdata[lce_tlf_pkg::QSEC_LSB +: lce_tlf_pkg::REG_BITS];

	// Effective length and strides.
	assign n_eff  = (int'(len_q) < MAX_LEN) ? len_q : lce_tlf_pkg::reg_t'(MAX_LEN);
	assign sf_eff = (fine_q == '0) ? lce_tlf_pkg::reg_t'(1) : fine_q;
	assign sc_eff = (coarse_q < sf_eff) ? sf_eff : coarse_q;

	assign in_far   = (in_i > in_j) ? in_i : in_j;
	assign in_bound = (in_far < n_eff) ? n_eff - in_far : '0;
	assign in_self  = (in_i < n_eff) ? n_eff - in_i : '0;

	assign accept    = s_tvalid && s_tready;
	assign load_acc  = accept && (s_tuser == lce_tlf_pkg::OP_LOAD);
	assign query_acc = accept && (s_tuser == lce_tlf_pkg::OP_QUERY);

	// Running group ids restart at this rank when the common prefix is short.
	assign fine_run_d   = (in_lcp < sf_eff) ? in_rank : fine_run_q;
	assign coarse_run_d = (in_lcp < sc_eff) ? in_rank : coarse_run_q;

	// Positions compared in this step of a query.
	assign pos_a   = lce_tlf_pkg::sum_t'(i_q) + t_q;
	assign pos_b   = lce_tlf_pkg::sum_t'(j_q) + t_q;
	assign raddr_a = AW'(pos_a);
	assign raddr_b = AW'(pos_b);

	always_comb begin
		case (level_q)
			lce_tlf_pkg::LVL_COARSE: begin
				step  = lce_tlf_pkg::sum_t'(sc_eff);
				match = inr_q && (grp_a[GW-1 -: lce_tlf_pkg::GROUP_BITS] ==
					grp_b[GW-1 -: lce_tlf_pkg::GROUP_BITS]);
			end
			lce_tlf_pkg::LVL_FINE: begin
				step  = lce_tlf_pkg::sum_t'(sf_eff);
				match = inr_q && (grp_a[lce_tlf_pkg::GROUP_BITS-1:0] ==
					grp_b[lce_tlf_pkg::GROUP_BITS-1:0]);
			end
			default: begin
				step  = lce_tlf_pkg::sum_t'(1);
				match = inr_q && (text_a == text_b);
			end
		endcase
	end

	assign result = (t_q > lce_tlf_pkg::sum_t'(bound_q)) ? bound_q
		: lce_tlf_pkg::reg_t'(t_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lce_tlf_pkg::S_IDLE: begin
				if (query_acc) begin
					state_d = (in_i == in_j) ? lce_tlf_pkg::S_DONE : lce_tlf_pkg::S_READ;
				end
			end
			lce_tlf_pkg::S_READ: begin
				state_d = lce_tlf_pkg::S_CMP;
			end
			lce_tlf_pkg::S_CMP: begin
				if (!match && level_q == lce_tlf_pkg::LVL_CHAR) begin
					state_d = lce_tlf_pkg::S_DONE;
				end else begin
					state_d = lce_tlf_pkg::S_READ;
				end
			end
			lce_tlf_pkg::S_DONE: begin
				if (!m_valid_q || m_tready) begin
					state_d = lce_tlf_pkg::S_IDLE;
				end
			end
			default: state_d = lce_tlf_pkg::S_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			lce_tlf_pkg::S_IDLE: s_tready = 1'b1;
			lce_tlf_pkg::S_DONE: out_load = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	assign text_we = load_acc && (int'(in_rank) < MAX_LEN);
	assign grp_we  = load_acc && (int'(in_start) < MAX_LEN);

	lce_tlf_ram #(
		.WIDTH(lce_tlf_pkg::CHAR_BITS),
		.DEPTH(MAX_LEN)
	) u_text_ram (
		.clk     (clk),
		.we      (text_we),
		.waddr   (AW'(in_rank)),
		.wdata   (in_char),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (text_a),
		.rdata_b (text_b)
	);

	// Coarse id in the upper half, fine id in the lower half.
	lce_tlf_ram #(
		.WIDTH(GW),
		.DEPTH(MAX_LEN)
	) u_group_ram (
		.clk     (clk),
		.we      (grp_we),
		.waddr   (AW'(in_start)),
		.wdata   ({coarse_run_d, fine_run_d}),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (grp_a),
		.rdata_b (grp_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lce_tlf_pkg::S_IDLE;
			level_q      <= lce_tlf_pkg::LVL_COARSE;
			len_q        <= '0;
			fine_q       <= lce_tlf_pkg::reg_t'(1);
			coarse_q     <= lce_tlf_pkg::reg_t'(1);
			fine_run_q   <= '0;
			coarse_run_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					lce_tlf_pkg::REG_STRING_LENGTH: len_q    <= cfg_wdata;
					lce_tlf_pkg::REG_FINE_STRIDE:   fine_q   <= cfg_wdata;
					lce_tlf_pkg::REG_COARSE_STRIDE: coarse_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (load_acc) begin
				fine_run_q   <= fine_run_d;
				coarse_run_q <= coarse_run_d;
			end
			if (query_acc) begin
				level_q <= lce_tlf_pkg::LVL_COARSE;
			end else if (state_q == lce_tlf_pkg::S_CMP && !match) begin
				level_q <= (level_q == lce_tlf_pkg::LVL_COARSE) ? lce_tlf_pkg::LVL_FINE
					: lce_tlf_pkg::LVL_CHAR;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Query datapath; no reset needed.
	always_ff @(posedge clk) begin
		if (query_acc) begin
			i_q     <= in_i;
			j_q     <= in_j;
			bound_q <= in_bound;
			t_q     <= (in_i == in_j) ? lce_tlf_pkg::sum_t'(in_self) : '0;
		end else if (state_q == lce_tlf_pkg::S_CMP && match) begin
			t_q <= t_q + step;
		end
		if (state_q == lce_tlf_pkg::S_READ) begin
			inr_q <= (pos_a < lce_tlf_pkg::sum_t'(n_eff)) &&
				(pos_b < lce_tlf_pkg::sum_t'(n_eff));
		end
		if (out_load) begin
			m_len_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = lce_tlf_pkg::M_TDATA_BITS'(m_len_q);

endmodule

// ===== design/lce_tlf_ram.sv =====
// Generic synchronous RAM: one write port and two read ports, registered reads.
// Stands alone; used by the LCE core for the text and group stores.
module lce_tlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== design/lce_tlf_checker.sv =====
// Port-level checks for the LCE core, bound to every instance of the top level.
// Depends on lce_tlf_pkg for the item kinds and the output width.
module lce_tlf_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 s_tuser,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [lce_tlf_pkg::M_TDATA_BITS-1:0] m_tdata
);

	// A result waiting on the output must hold still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A query occupies the core, so input is closed right after it.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == lce_tlf_pkg::OP_QUERY |=> !s_tready)
		else $error("input open right after a query item");

	// A load leaves the input open right after it.
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == lce_tlf_pkg::OP_LOAD |=> s_tready)
		else $error("input closed after a load item");

	// A new result only shows up at the end of a query.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a query in progress");

endmodule

bind lce_two_level_fingerprint_core lce_tlf_checker u_lce_tlf_checker (.*);
